FILE: rtl/diff_drive_odometry_assert.svh
// Assertion macros shared by the odometry RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef DIFF_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_ASSERT_SVH

`define DDO_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("ddo: same-cycle property failed");

`define DDO_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("ddo: next-cycle property failed");

`endif

FILE: rtl/ddo_pkg.sv
// Package for the differential drive odometry block: word types, register
// codes, fixed-point constants and the CORDIC arctangent table. No dependencies.
package ddo_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_TRACK   = 2'd1;

  localparam logic [CFG_DATA_W-1:0] WHEEL_RADIUS_RST = 16'd1966;
  localparam logic [CFG_DATA_W-1:0] HALF_TRACK_RST   = 16'd6554;

  localparam logic [63:0] Q30_PI      = 64'd3373259426;
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
  localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;
  localparam logic [63:0] Q30_GAIN    = 64'd652032874;

  localparam int ATAN_DEPTH = 24;
  localparam logic [31:0] ATAN_Q30 [ATAN_DEPTH] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  // Shared multiplier and divider geometry.
  localparam int SPLIT     = 17;
  localparam int MUL_A_W   = 42;
  localparam int MUL_B_W   = SPLIT + 1;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int DVD_W     = 48;
  localparam int MOD_STEPS = 32;
  localparam int DTH_STEPS = DVD_W;
  localparam int CNT_W     = 6;

  typedef struct packed {
    logic signed [31:0] left_angle;
    logic signed [31:0] right_angle_raw;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
  } out_word_t;

  function automatic logic [31:0] from_q30(input logic [63:0] v, input int frac);
    logic [63:0] s;
    s = (v + (64'd1 << (29 - frac))) >> (30 - frac);
    return s[31:0];
  endfunction

endpackage

FILE: rtl/diff_drive_odometry.sv
// Differential drive wheel odometry with a CORDIC for sine and cosine.
// A new input word is taken only from idle, once the previous result has been
// posted; each word runs the 32-step heading modulo, the CORDIC loop and the
// 48-step heading divide.
// Reset (synchronous, rst_n low) zeroes pose and previous angles and loads the
// default radius and half track. Depends on ddo_pkg and the assertion header.
`include "diff_drive_odometry_assert.svh"

module diff_drive_odometry
  import ddo_pkg::*;
#(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data
);

  localparam int ACC_W = FRAC_BITS + 33;
  localparam int IW    = $clog2(ATAN_DEPTH);
  localparam logic [IW-1:0] CORDIC_LAST = IW'(CORDIC_STEPS - 1);

  localparam logic [31:0]        TPI_FX     = from_q30(Q30_TWO_PI, FRAC_BITS);
  localparam logic signed [31:0] PI_FX      = signed'(from_q30(Q30_PI, FRAC_BITS));
  localparam logic signed [31:0] HPI_FX     = signed'(from_q30(Q30_HALF_PI, FRAC_BITS));
  localparam logic signed [31:0] NEG_HPI_FX = -HPI_FX;
  localparam logic signed [31:0] GAIN_FX    = signed'(from_q30(Q30_GAIN, FRAC_BITS));

  typedef enum logic [3:0] {
    S_IDLE, S_MOD, S_RED1, S_RED2, S_FOLD, S_CORDIC, S_MUL_TH, S_MUL_T,
    S_DTH, S_MC0, S_MC1, S_MS0, S_MS1, S_DY, S_OUT
  } state_t;

  state_t                     state_r;
  logic                       out_valid_r;
  logic [CFG_DATA_W-1:0]      radius_r;
  logic [CFG_DATA_W-1:0]      htrack_r;
  logic [31:0]                prev_l_r;
  logic [31:0]                prev_rt_r;
  logic [31:0]                acc_x_r;
  logic [31:0]                acc_y_r;
  logic [31:0]                acc_h_r;
  logic [31:0]                dl_r;
  logic [31:0]                dr_r;
  logic signed [32:0]         sum_r;
  logic signed [32:0]         diff_r;
  logic                       h_neg_r;
  logic [DVD_W-1:0]           dvd_r;
  logic [31:0]                rem_r;
  logic [31:0]                quo_r;
  logic [31:0]                dvs_r;
  logic [CNT_W-1:0]           cnt_r;
  logic signed [31:0]         ang_r;
  logic signed [31:0]         x_r;
  logic signed [31:0]         y_r;
  logic [IW-1:0]              i_r;
  logic                       neg_r;
  logic signed [31:0]         cs_r;
  logic signed [31:0]         sn_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [MUL_A_W-1:0]  t_r;
  logic                       p_neg_r;
  logic [ACC_W-1:0]           dsum_r;
  logic [31:0]                dx_r;
  logic [31:0]                dy_r;
  logic [31:0]                dth_r;

  logic [32:0]                trial;
  logic [32:0]                trial_sub;
  logic                       fits;
  logic [31:0]                rem_nxt;
  logic [31:0]                quo_nxt;
  logic signed [31:0]         atan_v;
  logic signed [31:0]         x_sh;
  logic signed [31:0]         y_sh;
  logic signed [31:0]         x_nxt;
  logic signed [31:0]         y_nxt;
  logic signed [31:0]         ang_nxt;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic signed [PROD_W-1:0]   t_full;
  logic [PROD_W-1:0]          pmag;
  logic [31:0]                hmag;
  logic [31:0]                cur_rt;
  logic [ACC_W-1:0]           hi_sum;
  logic signed [31:0]         cs_sh;
  logic signed [31:0]         sn_sh;
  logic [CFG_DATA_W:0]        dvs_dth;
  logic                       post;

  // Restoring divide step, shared by the heading modulo and the heading rate.
  always_comb begin
    trial     = {rem_r, dvd_r[DVD_W-1]};
    trial_sub = trial - {1'b0, dvs_r};
    fits      = trial >= {1'b0, dvs_r};
    rem_nxt   = fits ? trial_sub[31:0] : trial[31:0];
    quo_nxt   = {quo_r[30:0], fits};
  end

  // One CORDIC rotation per cycle.
  always_comb begin
    atan_v = signed'(from_q30({32'd0, ATAN_Q30[i_r]}, FRAC_BITS));
    x_sh   = x_r >>> i_r;
    y_sh   = y_r >>> i_r;
    if (!ang_r[31]) begin
      x_nxt   = x_r - y_sh;
      y_nxt   = y_r + x_sh;
      ang_nxt = ang_r - atan_v;
    end else begin
      x_nxt   = x_r + y_sh;
      y_nxt   = y_r - x_sh;
      ang_nxt = ang_r + atan_v;
    end
  end

  // Shared multiplier operand selection.
  always_comb begin
    cs_sh = cs_r >>> SPLIT;
    sn_sh = sn_r >>> SPLIT;
    unique case (state_r)
      S_MUL_TH: begin
        mul_a = {{(MUL_A_W-33){diff_r[32]}}, diff_r};
        mul_b = {{(MUL_B_W-CFG_DATA_W){1'b0}}, radius_r};
      end
      S_MUL_T: begin
        mul_a = {{(MUL_A_W-33){sum_r[32]}}, sum_r};
        mul_b = {{(MUL_B_W-CFG_DATA_W){1'b0}}, radius_r};
      end
      S_MC0: begin
        mul_a = t_r;
        mul_b = {1'b0, cs_r[SPLIT-1:0]};
      end
      S_MC1: begin
        mul_a = t_r;
        mul_b = cs_sh[MUL_B_W-1:0];
      end
      S_MS0: begin
        mul_a = t_r;
        mul_b = {1'b0, sn_r[SPLIT-1:0]};
      end
      S_MS1: begin
        mul_a = t_r;
        mul_b = sn_sh[MUL_B_W-1:0];
      end
      default: begin
        mul_a = t_r;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign t_full  = mul_p >>> FRAC_BITS;
  assign pmag    = prod_r[PROD_W-1] ? (PROD_W'(0) - prod_r) : prod_r;
  assign hmag    = acc_h_r[31] ? (32'd0 - acc_h_r) : acc_h_r;
  assign cur_rt  = 32'd0 - in_data.right_angle_raw;
  assign hi_sum  = dsum_r + {prod_r[ACC_W-1-SPLIT:0], {SPLIT{1'b0}}};
  assign dvs_dth = {(htrack_r == '0) ? CFG_DATA_W'(1) : htrack_r, 1'b0};
  assign post    = (state_r == S_OUT) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      radius_r    <= WHEEL_RADIUS_RST;
      htrack_r    <= HALF_TRACK_RST;
      prev_l_r    <= '0;
      prev_rt_r   <= '0;
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      acc_h_r     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WHEEL_RADIUS: radius_r <= cfg_wdata;
          CFG_HALF_TRACK:   htrack_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (out_valid_r && out_ready && !post) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            dl_r      <= in_data.left_angle - prev_l_r;
            dr_r      <= cur_rt - prev_rt_r;
            prev_l_r  <= in_data.left_angle;
            prev_rt_r <= cur_rt;
            h_neg_r   <= acc_h_r[31];
            dvd_r     <= {hmag, {(DVD_W-32){1'b0}}};
            dvs_r     <= TPI_FX;
            rem_r     <= '0;
            cnt_r     <= CNT_W'(MOD_STEPS);
            state_r   <= S_MOD;
          end
        end
        S_MOD, S_DTH: begin
          dvd_r <= dvd_r << 1;
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            state_r <= (state_r == S_MOD) ? S_RED1 : S_MC0;
          end
        end
        S_RED1: begin
          sum_r   <= {dr_r[31], dr_r} + {dl_r[31], dl_r};
          diff_r  <= {dr_r[31], dr_r} - {dl_r[31], dl_r};
          ang_r   <= (h_neg_r && rem_r != '0) ? signed'(TPI_FX - rem_r) : signed'(rem_r);
          state_r <= S_RED2;
        end
        S_RED2: begin
          if (ang_r > PI_FX) begin
            ang_r <= ang_r - signed'(TPI_FX);
          end
          state_r <= S_FOLD;
        end
        S_FOLD: begin
          if (ang_r > HPI_FX) begin
            ang_r <= ang_r - PI_FX;
            neg_r <= 1'b1;
          end else if (ang_r < NEG_HPI_FX) begin
            ang_r <= ang_r + PI_FX;
            neg_r <= 1'b1;
          end else begin
            neg_r <= 1'b0;
          end
          x_r     <= GAIN_FX;
          y_r     <= '0;
          i_r     <= '0;
          state_r <= S_CORDIC;
        end
        S_CORDIC: begin
          x_r   <= x_nxt;
          y_r   <= y_nxt;
          ang_r <= ang_nxt;
          i_r   <= i_r + IW'(1);
          if (i_r == CORDIC_LAST) begin
            state_r <= S_MUL_TH;
          end
        end
        S_MUL_TH: begin
          cs_r    <= neg_r ? -x_r : x_r;
          sn_r    <= neg_r ? -y_r : y_r;
          prod_r  <= mul_p;
          state_r <= S_MUL_T;
        end
        S_MUL_T: begin
          t_r     <= t_full[MUL_A_W-1:0];
          p_neg_r <= prod_r[PROD_W-1];
          dvd_r   <= pmag[DVD_W-1:0];
          dvs_r   <= {{(32-CFG_DATA_W-1){1'b0}}, dvs_dth};
          rem_r   <= '0;
          cnt_r   <= CNT_W'(DTH_STEPS);
          state_r <= S_DTH;
        end
        S_MC0: begin
          dth_r   <= p_neg_r ? (32'd0 - quo_r) : quo_r;
          prod_r  <= mul_p;
          state_r <= S_MC1;
        end
        S_MC1: begin
          dsum_r  <= prod_r[ACC_W-1:0];
          prod_r  <= mul_p;
          state_r <= S_MS0;
        end
        S_MS0: begin
          dx_r    <= hi_sum[FRAC_BITS+32:FRAC_BITS+1];
          prod_r  <= mul_p;
          state_r <= S_MS1;
        end
        S_MS1: begin
          dsum_r  <= prod_r[ACC_W-1:0];
          prod_r  <= mul_p;
          state_r <= S_DY;
        end
        S_DY: begin
          dy_r    <= hi_sum[FRAC_BITS+32:FRAC_BITS+1];
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (post) begin
            acc_x_r     <= acc_x_r + dx_r;
            acc_y_r     <= acc_y_r + dy_r;
            acc_h_r     <= acc_h_r + dth_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_data.pos_x   = signed'(acc_x_r);
  assign out_data.pos_y   = signed'(acc_y_r);
  assign out_data.heading = signed'(acc_h_r);

  `DDO_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `DDO_ASSERT_NEXT(a_pose_only_on_post, state_r != S_OUT, $stable(acc_x_r) && $stable(acc_y_r) && $stable(acc_h_r))
  `DDO_ASSERT_SAME(a_rem_below_divisor, state_r == S_MOD || state_r == S_DTH, rem_r < dvs_r)
  `DDO_ASSERT_SAME(a_cordic_count, state_r == S_CORDIC, i_r <= CORDIC_LAST)

endmodule
